/* hw/rtl/cds_pkg.sv */
// Shared types, constants and calendar helper functions for the date stepper.
// Used by cds_ctrl, cds_dp and calendar_date_stepper; depends on nothing else.
`default_nettype none

package cds_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int DCNT_W  = 11;
	localparam int KIND_W  = 2;
	localparam int REL_W   = 2;

	localparam logic [YEAR_W-1:0]  TOP_YEAR   = 14'd9999;
	localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2000;
	localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd1;
	localparam logic [DAY_W-1:0]   RST_DAY    = 5'd1;
	localparam logic [WDAY_W-1:0]  RST_WDAY   = 3'd6;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
	localparam logic [WDAY_W-1:0]  LAST_WDAY  = 3'd6;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_CMP  = 2'd2
	} kind_t;

	typedef enum logic [REL_W-1:0] {
		REL_SAME    = 2'd0,
		REL_LATER   = 2'd1,
		REL_EARLIER = 2'd2
	} rel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic work_done;
	} dp_status_t;

	// Leap-year test. The quotient by 100 comes from a reciprocal multiply,
	// exact for every 14-bit year; the 400 rule then looks at that quotient.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [26:0]       prod;
		logic [7:0]        q;
		logic [YEAR_W-1:0] hund;
		logic              div100;
		prod   = 27'(y) * 27'(5243);
		q      = prod[26:19];
		hund   = YEAR_W'({q, 6'b0}) + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0});
		div100 = (hund == y);
		return div100 ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
	endfunction

	// Month length; zero for a month code outside January to December.
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
	                                             input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = is_leap(y) ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cds_ctrl.sv */
// Sequencing state machine for the date stepper: handshakes and datapath commands.
// Depends on cds_pkg for the state encoding and the command and status structs.
`default_nettype none

module cds_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cds_pkg::dp_cmd_t        cmd,
	input  wire cds_pkg::dp_status_t status
);
	import cds_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.work_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// The output register is free once its beat leaves this edge.
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || !out_stall))
		else $error("result published over a beat still waiting");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EXEC))
		else $error("accepted beat did not start execution");
	a_stalled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cds_dp.sv */
// Datapath of the date stepper: date state, item registers, day stepper,
// load check, compare and the output register. Depends on cds_pkg.
`default_nettype none

module cds_dp #(
	parameter int STEP_LIMIT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cds_pkg::dp_cmd_t               cmd,
	output cds_pkg::dp_status_t                 status,
	input  wire logic [cds_pkg::KIND_W-1:0]     kind,
	input  wire logic [cds_pkg::DAY_W-1:0]      arg_day,
	input  wire logic [cds_pkg::MONTH_W-1:0]    arg_month,
	input  wire logic [cds_pkg::YEAR_W-1:0]     arg_year,
	input  wire logic [cds_pkg::WDAY_W-1:0]     arg_weekday,
	input  wire logic signed [cds_pkg::DCNT_W-1:0] day_count,
	output logic [cds_pkg::DAY_W-1:0]           cur_day,
	output logic [cds_pkg::MONTH_W-1:0]         cur_month,
	output logic [cds_pkg::YEAR_W-1:0]          cur_year,
	output logic [cds_pkg::WDAY_W-1:0]          cur_weekday,
	output logic                                error_flag,
	output logic [cds_pkg::REL_W-1:0]           relation
);
	import cds_pkg::*;

	localparam int CNT_W = $clog2(STEP_LIMIT + 1);
	localparam int CMP_W = (CNT_W > DCNT_W) ? CNT_W : DCNT_W;

	// Date state.
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [WDAY_W-1:0]  wday_q;

	// Captured item.
	logic [KIND_W-1:0]  kind_q;
	logic [DAY_W-1:0]   arg_day_q;
	logic [MONTH_W-1:0] arg_month_q;
	logic [YEAR_W-1:0]  arg_year_q;
	logic [WDAY_W-1:0]  arg_wday_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               err_q;
	logic [REL_W-1:0]   rel_q;

	// Output register.
	logic [DAY_W-1:0]   out_day_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic [WDAY_W-1:0]  out_wday_q;
	logic               out_err_q;
	logic [REL_W-1:0]   out_rel_q;

	logic [DCNT_W-1:0]  raw;
	logic [DCNT_W-1:0]  mag;
	logic [CMP_W-1:0]   mag_ext;
	logic [CMP_W-1:0]   lim_ext;
	logic [CNT_W-1:0]   cnt_init;

	logic [DAY_W-1:0]   step_day;
	logic [MONTH_W-1:0] step_month;
	logic [YEAR_W-1:0]  step_year;
	logic [WDAY_W-1:0]  step_wday;
	logic               step_blocked;
	logic [MONTH_W-1:0] prev_month;
	logic               load_ok;
	logic [REL_W-1:0]   cmp_rel;
	logic               do_step;

	// Step count magnitude, clamped to the step limit.
	always_comb begin
		raw      = day_count;
		mag      = raw[DCNT_W-1] ? (~raw + DCNT_W'(1)) : raw;
		mag_ext  = CMP_W'(mag);
		lim_ext  = CMP_W'(STEP_LIMIT);
		cnt_init = (mag_ext > lim_ext) ? CNT_W'(lim_ext) : CNT_W'(mag_ext);
	end

	// One calendar day forward or backward from the stored date.
	always_comb begin
		step_day     = day_q;
		step_month   = month_q;
		step_year    = year_q;
		step_wday    = wday_q;
		step_blocked = 1'b0;
		prev_month   = month_q - MONTH_W'(1);
		if (!neg_q) begin
			if (day_q >= days_in(month_q, year_q)) begin
				if (month_q >= LAST_MONTH) begin
					if (year_q >= TOP_YEAR) begin
						step_blocked = 1'b1;
					end else begin
						step_year  = year_q + YEAR_W'(1);
						step_month = MONTH_W'(1);
					end
				end else begin
					step_month = month_q + MONTH_W'(1);
				end
				step_day = DAY_W'(1);
			end else begin
				step_day = day_q + DAY_W'(1);
			end
			step_wday = (wday_q >= LAST_WDAY) ? '0 : wday_q + WDAY_W'(1);
		end else begin
			if (day_q <= DAY_W'(1)) begin
				if (month_q <= MONTH_W'(1)) begin
					if (year_q <= YEAR_W'(1)) begin
						step_blocked = 1'b1;
					end else begin
						step_year  = year_q - YEAR_W'(1);
						step_month = LAST_MONTH;
					end
					// December has 31 days in every year.
					step_day = DAY_W'(31);
				end else begin
					step_month = prev_month;
					step_day   = days_in(prev_month, year_q);
				end
			end else begin
				step_day = day_q - DAY_W'(1);
			end
			step_wday = (wday_q == '0) ? LAST_WDAY : wday_q - WDAY_W'(1);
		end
	end

	always_comb begin
		load_ok = (arg_month_q >= MONTH_W'(1)) && (arg_month_q <= LAST_MONTH) &&
		          (arg_year_q >= YEAR_W'(1)) && (arg_year_q <= TOP_YEAR) &&
		          (arg_day_q >= DAY_W'(1)) &&
		          (arg_day_q <= days_in(arg_month_q, arg_year_q)) &&
		          (arg_wday_q <= LAST_WDAY);
		if (year_q != arg_year_q) begin
			cmp_rel = (year_q > arg_year_q) ? REL_LATER : REL_EARLIER;
		end else if (month_q != arg_month_q) begin
			cmp_rel = (month_q > arg_month_q) ? REL_LATER : REL_EARLIER;
		end else if (day_q != arg_day_q) begin
			cmp_rel = (day_q > arg_day_q) ? REL_LATER : REL_EARLIER;
		end else begin
			cmp_rel = REL_SAME;
		end
	end

	assign status.work_done = (kind_q != KIND_ADD) || (cnt_q == '0) || err_q;
	assign do_step = cmd.exec && (kind_q == KIND_ADD) && (cnt_q != '0) && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= RST_DAY;
			month_q <= RST_MONTH;
			year_q  <= RST_YEAR;
			wday_q  <= RST_WDAY;
			kind_q  <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
			rel_q   <= REL_SAME;
		end else if (cmd.capture) begin
			kind_q <= kind;
			neg_q  <= day_count[DCNT_W-1];
			cnt_q  <= cnt_init;
			err_q  <= 1'b0;
			rel_q  <= REL_SAME;
		end else if (cmd.exec) begin
			unique case (kind_q)
				KIND_LOAD: begin
					if (load_ok) begin
						day_q   <= arg_day_q;
						month_q <= arg_month_q;
						year_q  <= arg_year_q;
						wday_q  <= arg_wday_q;
					end else begin
						err_q <= 1'b1;
					end
				end
				KIND_ADD: begin
					if (do_step) begin
						// A blocked step ends the walk with the date at the limit.
						if (step_blocked) begin
							err_q <= 1'b1;
						end else begin
							day_q   <= step_day;
							month_q <= step_month;
							year_q  <= step_year;
							wday_q  <= step_wday;
							cnt_q   <= cnt_q - CNT_W'(1);
						end
					end
				end
				KIND_CMP: begin
					rel_q <= cmp_rel;
				end
				default: begin
					rel_q <= REL_SAME;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			arg_day_q   <= arg_day;
			arg_month_q <= arg_month;
			arg_year_q  <= arg_year;
			arg_wday_q  <= arg_weekday;
		end
		if (cmd.publish) begin
			out_day_q   <= day_q;
			out_month_q <= month_q;
			out_year_q  <= year_q;
			out_wday_q  <= wday_q;
			out_err_q   <= err_q;
			out_rel_q   <= rel_q;
		end
	end

	assign cur_day     = out_day_q;
	assign cur_month   = out_month_q;
	assign cur_year    = out_year_q;
	assign cur_weekday = out_wday_q;
	assign error_flag  = out_err_q;
	assign relation    = out_rel_q;

`ifndef SYNTHESIS
	a_date_month: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= MONTH_W'(1)) && (month_q <= LAST_MONTH) &&
		(year_q >= YEAR_W'(1)) && (year_q <= TOP_YEAR) && (wday_q <= LAST_WDAY))
		else $error("stored date left the valid range");
	a_date_day: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q >= DAY_W'(1)) && (day_q <= days_in(month_q, year_q)))
		else $error("stored day beyond month length");
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && !step_blocked) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("step counter did not follow a taken step");
`endif

endmodule

`default_nettype wire

/* hw/rtl/calendar_date_stepper.sv */
// Gregorian date stepper: load, add signed days or compare against the stored date.
// Top level; instantiates cds_ctrl and cds_dp, depends on cds_pkg.
//
// Usage: one input channel (in_valid/in_stall) carries an item; a beat is taken
// when in_valid is high and in_stall low. Each item gives one result beat on the
// output channel (out_valid/out_stall) with the stored date after the item, the
// error flag and, for a compare, the relation.
// Sequence: the item is captured, run in the execute state and then published
// into the output register. An add of n days (n clamped to STEP_LIMIT) stays in
// the execute state, one calendar day per cycle through the single day stepper.
// A walk that hits 1 January of year 1 or 31 December of 9999 ends early.
// The block takes one item at a time and accepts no new input beat until the
// result is published; the next input beat can be taken while a finished result
// still waits in the output register.
// When the receiver stalls, the result stays put and the block waits with the
// next finished result until the output register is free.
// Reset (arst_n low) sets the date to Saturday 1 January 2000 and empties the
// output register.
`default_nettype none

module calendar_date_stepper #(
	parameter int STEP_LIMIT = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [cds_pkg::KIND_W-1:0]        kind,
	input  wire logic [cds_pkg::DAY_W-1:0]         arg_day,
	input  wire logic [cds_pkg::MONTH_W-1:0]       arg_month,
	input  wire logic [cds_pkg::YEAR_W-1:0]        arg_year,
	input  wire logic [cds_pkg::WDAY_W-1:0]        arg_weekday,
	input  wire logic signed [cds_pkg::DCNT_W-1:0] day_count,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [cds_pkg::DAY_W-1:0]              cur_day,
	output logic [cds_pkg::MONTH_W-1:0]            cur_month,
	output logic [cds_pkg::YEAR_W-1:0]             cur_year,
	output logic [cds_pkg::WDAY_W-1:0]             cur_weekday,
	output logic                                   error_flag,
	output logic [cds_pkg::REL_W-1:0]              relation
);
	import cds_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	cds_dp #(
		.STEP_LIMIT (STEP_LIMIT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.kind        (kind),
		.arg_day     (arg_day),
		.arg_month   (arg_month),
		.arg_year    (arg_year),
		.arg_weekday (arg_weekday),
		.day_count   (day_count),
		.cur_day     (cur_day),
		.cur_month   (cur_month),
		.cur_year    (cur_year),
		.cur_weekday (cur_weekday),
		.error_flag  (error_flag),
		.relation    (relation)
	);

endmodule

`default_nettype wire
